// ===== rtl/cpu8ld_pkg.sv =====
package cpu8ld_pkg;

   // memory address width, PC and data pointers stay 16 bits
   localparam int ADDR_BITS = 16;
   localparam int MEM_DEPTH = 1 << ADDR_BITS;
   localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

   // request kinds
   localparam logic [1:0] KIND_EXEC    = 2'd0;
   localparam logic [1:0] KIND_PRELOAD = 2'd1;
   localparam logic [1:0] KIND_SETPC   = 2'd2;

   // opcode prefixes
   localparam logic [1:0] PFX_NONE = 2'd0;
   localparam logic [1:0] PFX_DD   = 2'd1;
   localparam logic [1:0] PFX_FD   = 2'd2;
   localparam logic [1:0] PFX_ED   = 2'd3;

   // register file slots
   localparam logic [2:0] REG_MEM = 3'd6;
   localparam logic [2:0] REG_F   = 3'd6;
   localparam logic [2:0] REG_A   = 3'd7;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_SP = 2'd3;

   // opcode masks and patterns
   localparam logic [7:0] MASK_RN   = 8'hC7;
   localparam logic [7:0] MASK_DD   = 8'hCF;
   localparam logic [7:0] PAT_RN    = 8'h06;
   localparam logic [7:0] PAT_DDNN  = 8'h01;
   localparam logic [7:0] PAT_ED_RD = 8'h4B;
   localparam logic [7:0] PAT_ED_WR = 8'h43;
   localparam logic [7:0] OP_HALT   = 8'h76;
   localparam logic [7:0] OP_A_BC   = 8'h0A;
   localparam logic [7:0] OP_A_DE   = 8'h1A;
   localparam logic [7:0] OP_BC_A   = 8'h02;
   localparam logic [7:0] OP_DE_A   = 8'h12;
   localparam logic [7:0] OP_A_NN   = 8'h3A;
   localparam logic [7:0] OP_NN_A   = 8'h32;
   localparam logic [7:0] OP_HL_NN  = 8'h2A;
   localparam logic [7:0] OP_NN_HL  = 8'h22;
   localparam logic [7:0] OP_X_IMM  = 8'h21;
   localparam logic [7:0] OP_XD_N   = 8'h36;
   localparam logic [7:0] OP_SP_HL  = 8'hF9;
   localparam logic [7:0] OP_A_I    = 8'h57;
   localparam logic [7:0] OP_A_R    = 8'h5F;
   localparam logic [7:0] OP_I_A    = 8'h47;
   localparam logic [7:0] OP_R_A    = 8'h4F;
   localparam logic [7:0] FLAG_KEEP = 8'h29;
   localparam logic [7:0] FLAG_S    = 8'h80;
   localparam logic [7:0] FLAG_Z    = 8'h40;
   localparam logic [7:0] FLAG_PV   = 8'h04;

   typedef enum logic [2:0] {
      AM_NONE, AM_PAIR, AM_NN, AM_IDX
   } addr_mode_type;

   typedef enum logic [3:0] {
      SRC_REG, SRC_A, SRC_IMM0, SRC_IMM1, SRC_NN, SRC_MEM8, SRC_MEM16,
      SRC_PAIR, SRC_XR, SRC_I, SRC_R
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_REG, DST_A, DST_PAIR, DST_SP, DST_XR, DST_AF, DST_I, DST_R
   } dst_type;

   // decoded micro-operation
   typedef struct packed {
      logic          ok;
      logic [4:0]    tstates;
      logic [1:0]    ops;
      addr_mode_type amode;
      logic [1:0]    rd;
      logic [1:0]    wr;
      src_type       src;
      dst_type       dst;
      logic [1:0]    pr;
      logic [2:0]    sr;
      logic [2:0]    dr;
   } uop_type;

endpackage

// ===== rtl/cpu8ld_req_if.sv =====
interface cpu8ld_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  prefix;
   logic [7:0]  opcode;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, kind, prefix, opcode, address, data, input ready);
   modport sink (input valid, kind, prefix, opcode, address, data, output ready);
endinterface

// ===== rtl/cpu8ld_rsp_if.sv =====
interface cpu8ld_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pc_after;
   logic [7:0]  acc_value;
   logic [7:0]  flag_value;
   logic [15:0] loaded_value;
   logic [1:0]  write_count;
   logic [15:0] write_address;
   logic [4:0]  t_states;
   logic        unsupported;

   modport source (output valid, pc_after, acc_value, flag_value, loaded_value,
                   write_count, write_address, t_states, unsupported, input ready);
   modport sink (input valid, pc_after, acc_value, flag_value, loaded_value,
                 write_count, write_address, t_states, unsupported, output ready);
endinterface

// ===== rtl/cpu8ld_csr_if.sv =====
interface cpu8ld_csr_if;
   logic valid;
   logic ready;
   logic iff2_state;

   modport source (output valid, iff2_state, input ready);
   modport sink (input valid, iff2_state, output ready);
endinterface

// ===== rtl/cpu8ld_ram.sv =====
module cpu8ld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else if (en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cpu8ld_decode.sv =====
module cpu8ld_decode import cpu8ld_pkg::*; (
   input  logic [1:0] prefix,
   input  logic [7:0] opcode,
   output uop_type    uop
);

   logic [2:0] d;
   logic [2:0] s;
   logic [1:0] p;
   logic       rr_form;

   assign d = opcode[5:3];
   assign s = opcode[2:0];
   assign p = opcode[5:4];
   assign rr_form = (opcode[7:6] == 2'b01) && (opcode != OP_HALT);

   always_comb begin
      uop = '0;
      uop.amode = AM_NONE;
      uop.src = SRC_REG;
      uop.dst = DST_NONE;
      uop.sr = s;
      uop.dr = d;
      uop.pr = PAIR_HL;
      case (prefix)
         // unprefixed loads
         PFX_NONE: begin
            if (rr_form) begin
               uop.ok = 1'b1;
               if (s == REG_MEM) begin
                  uop.amode = AM_PAIR; uop.rd = 2'd1; uop.src = SRC_MEM8;
                  uop.dst = DST_REG; uop.tstates = 5'd7;
               end else if (d == REG_MEM) begin
                  uop.amode = AM_PAIR; uop.wr = 2'd1; uop.tstates = 5'd7;
               end else begin
                  uop.dst = DST_REG; uop.tstates = 5'd4;
               end
            end else if ((opcode & MASK_RN) == PAT_RN) begin
               uop.ok = 1'b1; uop.ops = 2'd1; uop.src = SRC_IMM0;
               if (d == REG_MEM) begin
                  uop.amode = AM_PAIR; uop.wr = 2'd1; uop.tstates = 5'd10;
               end else begin
                  uop.dst = DST_REG; uop.tstates = 5'd7;
               end
            end else if ((opcode & MASK_DD) == PAT_DDNN) begin
               uop.ok = 1'b1; uop.ops = 2'd2; uop.src = SRC_NN;
               uop.dst = DST_PAIR; uop.pr = p; uop.tstates = 5'd10;
            end else begin
               case (opcode)
                  OP_A_BC, OP_A_DE: begin
                     uop.ok = 1'b1; uop.amode = AM_PAIR; uop.pr = {1'b0, opcode[4]};
                     uop.rd = 2'd1; uop.src = SRC_MEM8; uop.dst = DST_A;
                     uop.tstates = 5'd7;
                  end
                  OP_BC_A, OP_DE_A: begin
                     uop.ok = 1'b1; uop.amode = AM_PAIR; uop.pr = {1'b0, opcode[4]};
                     uop.wr = 2'd1; uop.src = SRC_A; uop.tstates = 5'd7;
                  end
                  OP_A_NN: begin
                     uop.ok = 1'b1; uop.ops = 2'd2; uop.amode = AM_NN; uop.rd = 2'd1;
                     uop.src = SRC_MEM8; uop.dst = DST_A; uop.tstates = 5'd13;
                  end
                  OP_NN_A: begin
                     uop.ok = 1'b1; uop.ops = 2'd2; uop.amode = AM_NN; uop.wr = 2'd1;
                     uop.src = SRC_A; uop.tstates = 5'd13;
                  end
                  OP_HL_NN: begin
                     uop.ok = 1'b1; uop.ops = 2'd2; uop.amode = AM_NN; uop.rd = 2'd2;
                     uop.src = SRC_MEM16; uop.dst = DST_PAIR; uop.tstates = 5'd16;
                  end
                  OP_NN_HL: begin
                     uop.ok = 1'b1; uop.ops = 2'd2; uop.amode = AM_NN; uop.wr = 2'd2;
                     uop.src = SRC_PAIR; uop.tstates = 5'd16;
                  end
                  OP_SP_HL: begin
                     uop.ok = 1'b1; uop.src = SRC_PAIR; uop.dst = DST_SP;
                     uop.tstates = 5'd6;
                  end
                  default: ;
               endcase
            end
         end
         // IX / IY forms
         PFX_DD, PFX_FD: begin
            if (rr_form) begin
               if (s == REG_MEM) begin
                  uop.ok = 1'b1; uop.ops = 2'd1; uop.amode = AM_IDX; uop.rd = 2'd1;
                  uop.src = SRC_MEM8; uop.dst = DST_REG; uop.tstates = 5'd19;
               end else if (d == REG_MEM) begin
                  uop.ok = 1'b1; uop.ops = 2'd1; uop.amode = AM_IDX; uop.wr = 2'd1;
                  uop.tstates = 5'd19;
               end
            end else begin
               case (opcode)
                  OP_XD_N: begin
                     uop.ok = 1'b1; uop.ops = 2'd2; uop.amode = AM_IDX; uop.wr = 2'd1;
                     uop.src = SRC_IMM1; uop.tstates = 5'd19;
                  end
                  OP_X_IMM: begin
                     uop.ok = 1'b1; uop.ops = 2'd2; uop.src = SRC_NN; uop.dst = DST_XR;
                     uop.tstates = 5'd14;
                  end
                  OP_HL_NN: begin
                     uop.ok = 1'b1; uop.ops = 2'd2; uop.amode = AM_NN; uop.rd = 2'd2;
                     uop.src = SRC_MEM16; uop.dst = DST_XR; uop.tstates = 5'd20;
                  end
                  OP_NN_HL: begin
                     uop.ok = 1'b1; uop.ops = 2'd2; uop.amode = AM_NN; uop.wr = 2'd2;
                     uop.src = SRC_XR; uop.tstates = 5'd20;
                  end
                  OP_SP_HL: begin
                     uop.ok = 1'b1; uop.src = SRC_XR; uop.dst = DST_SP;
                     uop.tstates = 5'd10;
                  end
                  default: ;
               endcase
            end
         end
         // extended loads
         PFX_ED: begin
            if ((opcode & MASK_DD) == PAT_ED_RD) begin
               uop.ok = 1'b1; uop.ops = 2'd2; uop.amode = AM_NN; uop.rd = 2'd2;
               uop.src = SRC_MEM16; uop.dst = DST_PAIR; uop.pr = p; uop.tstates = 5'd20;
            end else if ((opcode & MASK_DD) == PAT_ED_WR) begin
               uop.ok = 1'b1; uop.ops = 2'd2; uop.amode = AM_NN; uop.wr = 2'd2;
               uop.src = SRC_PAIR; uop.pr = p; uop.tstates = 5'd20;
            end else begin
               case (opcode)
                  OP_A_I: begin
                     uop.ok = 1'b1; uop.src = SRC_I; uop.dst = DST_AF; uop.tstates = 5'd9;
                  end
                  OP_A_R: begin
                     uop.ok = 1'b1; uop.src = SRC_R; uop.dst = DST_AF; uop.tstates = 5'd9;
                  end
                  OP_I_A: begin
                     uop.ok = 1'b1; uop.src = SRC_A; uop.dst = DST_I; uop.tstates = 5'd9;
                  end
                  OP_R_A: begin
                     uop.ok = 1'b1; uop.src = SRC_A; uop.dst = DST_R; uop.tstates = 5'd9;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/cpu8_load_execute_unit.sv =====
// channel   dir  handshake     payload
// req_ch    in   valid/ready   kind, prefix, opcode, address, data
// rsp_ch    out  valid/ready   pc_after .. unsupported, one per request
// csr_ch    in   valid/ready   iff2_state, always ready
//
// one request at a time; after the accept an executed load steps through S_DECODE, any
// operand fetch, S_EADDR, any data read or write and S_COMMIT, every operand and data
// byte read taking the single memory port through a request and a wait state (write: S_WR)
// req_ch.ready is high only while no request is in flight or held on rsp_ch
// reset (synchronous) clears registers, PC, I, R and iff2; memory is not cleared
// a stalled response holds until rsp_ch.ready
module cpu8_load_execute_unit import cpu8ld_pkg::*; (
   input logic           clock,
   input logic           reset,
   cpu8ld_req_if.sink    req_ch,
   cpu8ld_rsp_if.source  rsp_ch,
   cpu8ld_csr_if.sink    csr_ch
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_PRELOAD, S_OPND, S_OPND_W, S_EADDR,
      S_RD, S_RD_W, S_WR, S_COMMIT, S_RESP
   } state_type;

   state_type   state_ff;
   logic [1:0]  kind_ff, pfx_ff;
   logic [7:0]  op_ff, data_ff;
   logic [15:0] addr_ff;
   logic [7:0]  regs_ff [8];
   logic [15:0] ix_ff, iy_ff, sp_ff, pc_ff, cur_pc_ff, ea_ff, wa_ff;
   logic [7:0]  i_ff, r_ff;
   logic        iff2_ff;
   logic [7:0]  b_ff [2];
   logic [7:0]  m_ff [2];
   logic [1:0]  cnt_ff;
   logic [15:0] loaded_ff, waddr_ff;
   logic [1:0]  wcnt_ff;
   logic [4:0]  ts_ff;
   logic        unsup_ff;

   uop_type     uop;
   logic [15:0] xr, pair_val, nn, val_in, ea_in, add_a, add_b, sum;
   logic [7:0]  flags_in;
   logic [1:0]  cnt_in;
   logic [ADDR_BITS-1:0] ram_addr;
   logic        ram_en, ram_we;
   logic [7:0]  ram_wdata, ram_rdata;

   cpu8ld_decode u_decode (.prefix(pfx_ff), .opcode(op_ff), .uop(uop));

   cpu8ld_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
      .clock(clock), .en(ram_en), .we(ram_we), .addr(ram_addr),
      .wdata(ram_wdata), .rdata(ram_rdata)
   );

   // operand views
   assign xr = (pfx_ff == PFX_FD) ? iy_ff : ix_ff;
   assign nn = {b_ff[1], b_ff[0]};
   assign cnt_in = 2'(cnt_ff + 2'd1);

   always_comb begin
      case (uop.pr)
         2'd0:    pair_val = {regs_ff[0], regs_ff[1]};
         2'd1:    pair_val = {regs_ff[2], regs_ff[3]};
         PAIR_HL: pair_val = {regs_ff[4], regs_ff[5]};
         default: pair_val = sp_ff;
      endcase
   end

   // source value of the load
   always_comb begin
      case (uop.src)
         SRC_REG:   val_in = {8'd0, regs_ff[uop.sr]};
         SRC_A:     val_in = {8'd0, regs_ff[REG_A]};
         SRC_IMM0:  val_in = {8'd0, b_ff[0]};
         SRC_IMM1:  val_in = {8'd0, b_ff[1]};
         SRC_NN:    val_in = nn;
         SRC_MEM8:  val_in = {8'd0, m_ff[0]};
         SRC_MEM16: val_in = {m_ff[1], m_ff[0]};
         SRC_PAIR:  val_in = pair_val;
         SRC_XR:    val_in = xr;
         SRC_I:     val_in = {8'd0, i_ff};
         SRC_R:     val_in = {8'd0, r_ff};
         default:   val_in = '0;
      endcase
   end

   // flags for LD A,I and LD A,R
   always_comb begin
      flags_in = (regs_ff[REG_F] & FLAG_KEEP) | (val_in[7:0] & FLAG_S);
      if (val_in[7:0] == 8'd0) flags_in = flags_in | FLAG_Z;
      if (iff2_ff) flags_in = flags_in | FLAG_PV;
   end

   // shared 16-bit adder: pc step, index + displacement, next data byte
   always_comb begin
      case (state_ff)
         S_OPND: begin
            add_a = cur_pc_ff; add_b = 16'd1;
         end
         S_EADDR: begin
            add_a = xr; add_b = {{8{b_ff[0][7]}}, b_ff[0]};
         end
         default: begin
            add_a = ea_ff; add_b = 16'd1;
         end
      endcase
   end
   assign sum = add_a + add_b;

   always_comb begin
      case (uop.amode)
         AM_PAIR: ea_in = pair_val;
         AM_NN:   ea_in = nn;
         AM_IDX:  ea_in = sum;
         default: ea_in = '0;
      endcase
   end

   // memory port
   assign ram_we = (state_ff == S_WR) || (state_ff == S_PRELOAD);
   assign ram_en = (state_ff == S_OPND) || (state_ff == S_RD);
   always_comb begin
      case (state_ff)
         S_OPND:    ram_addr = cur_pc_ff[ADDR_BITS-1:0];
         S_PRELOAD: ram_addr = addr_ff[ADDR_BITS-1:0];
         default:   ram_addr = ea_ff[ADDR_BITS-1:0];
      endcase
      if (state_ff == S_PRELOAD) ram_wdata = data_ff;
      else if (cnt_ff[0]) ram_wdata = val_in[15:8];
      else ram_wdata = val_in[7:0];
   end

   // configuration
   assign csr_ch.ready = 1'b1;

   // sequencer, architectural state and response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int k = 0; k < 8; k++) regs_ff[k] <= '0;
         ix_ff <= '0; iy_ff <= '0; sp_ff <= '0; pc_ff <= '0;
         i_ff <= '0; r_ff <= '0; iff2_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) iff2_ff <= csr_ch.iff2_state;
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  kind_ff <= req_ch.kind; pfx_ff <= req_ch.prefix;
                  op_ff <= req_ch.opcode; addr_ff <= req_ch.address;
                  data_ff <= req_ch.data; cur_pc_ff <= pc_ff;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               loaded_ff <= '0; wcnt_ff <= '0; waddr_ff <= '0; ts_ff <= '0;
               unsup_ff <= 1'b0; cnt_ff <= '0;
               case (kind_ff)
                  KIND_EXEC: begin
                     if (!uop.ok) begin
                        unsup_ff <= 1'b1; state_ff <= S_RESP;
                     end else if (uop.ops != 2'd0) begin
                        state_ff <= S_OPND;
                     end else begin
                        state_ff <= S_EADDR;
                     end
                  end
                  KIND_PRELOAD: state_ff <= S_PRELOAD;
                  KIND_SETPC: begin
                     pc_ff <= addr_ff; state_ff <= S_RESP;
                  end
                  default: state_ff <= S_RESP;
               endcase
            end
            S_PRELOAD: state_ff <= S_RESP;
            S_OPND: begin
               cur_pc_ff <= sum; state_ff <= S_OPND_W;
            end
            S_OPND_W: begin
               b_ff[cnt_ff[0]] <= ram_rdata;
               cnt_ff <= cnt_in;
               state_ff <= (cnt_in < uop.ops) ? S_OPND : S_EADDR;
            end
            S_EADDR: begin
               ea_ff <= ea_in; wa_ff <= ea_in & ADDR_MASK; cnt_ff <= '0;
               if (uop.rd != 2'd0) state_ff <= S_RD;
               else if (uop.wr != 2'd0) state_ff <= S_WR;
               else state_ff <= S_COMMIT;
            end
            S_RD: begin
               ea_ff <= sum; state_ff <= S_RD_W;
            end
            S_RD_W: begin
               m_ff[cnt_ff[0]] <= ram_rdata;
               cnt_ff <= cnt_in;
               state_ff <= (cnt_in < uop.rd) ? S_RD : S_COMMIT;
            end
            S_WR: begin
               ea_ff <= sum; cnt_ff <= cnt_in;
               if (!(cnt_in < uop.wr)) state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               case (uop.dst)
                  DST_REG: regs_ff[uop.dr] <= val_in[7:0];
                  DST_A:   regs_ff[REG_A] <= val_in[7:0];
                  DST_PAIR: begin
                     if (uop.pr == PAIR_SP) begin
                        sp_ff <= val_in;
                     end else begin
                        regs_ff[{uop.pr, 1'b0}] <= val_in[15:8];
                        regs_ff[{uop.pr, 1'b1}] <= val_in[7:0];
                     end
                  end
                  DST_SP: sp_ff <= val_in;
                  DST_XR: begin
                     if (pfx_ff == PFX_FD) iy_ff <= val_in;
                     else ix_ff <= val_in;
                  end
                  DST_AF: begin
                     regs_ff[REG_A] <= val_in[7:0];
                     regs_ff[REG_F] <= flags_in;
                  end
                  DST_I: i_ff <= val_in[7:0];
                  DST_R: r_ff <= val_in[7:0];
                  default: ;
               endcase
               pc_ff <= cur_pc_ff;
               loaded_ff <= val_in;
               wcnt_ff <= uop.wr;
               waddr_ff <= (uop.wr != 2'd0) ? wa_ff : 16'd0;
               ts_ff <= uop.tstates;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ch.ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_RESP);
   assign rsp_ch.pc_after = pc_ff;
   assign rsp_ch.acc_value = regs_ff[REG_A];
   assign rsp_ch.flag_value = regs_ff[REG_F];
   assign rsp_ch.loaded_value = loaded_ff;
   assign rsp_ch.write_count = wcnt_ff;
   assign rsp_ch.write_address = waddr_ff;
   assign rsp_ch.t_states = ts_ff;
   assign rsp_ch.unsupported = unsup_ff;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a response is pending");

   a_we_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_WR || state_ff == S_PRELOAD))
      else $error("memory write outside write or preload");

   a_wr_needs_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (uop.wr != 2'd0) && uop.ok)
      else $error("write step without decoded write");

   a_unsup_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.unsupported) |->
         (rsp_ch.write_count == 2'd0 && rsp_ch.t_states == 5'd0))
      else $error("unsupported opcode reported side effects");

   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_WR) |=> $stable(pc_ff))
      else $error("pc moved during data transfer");

endmodule

// ===== test/cpu8_load_execute_unit_test.sv =====
`timescale 1ns / 1ps

module cpu8_load_execute_unit_test;
   import cpu8ld_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_COUNT = 2000;
   localparam logic [1:0] KIND_NOP = 2'd3;

   typedef struct packed {
      logic [15:0] pc_after;
      logic [7:0]  acc_value;
      logic [7:0]  flag_value;
      logic [15:0] loaded_value;
      logic [1:0]  write_count;
      logic [15:0] write_address;
      logic [4:0]  t_states;
      logic        unsupported;
   } outcome_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  prefix;
      logic [7:0]  opcode;
      logic [15:0] address;
      logic [7:0]  data;
   } request_type;

   typedef struct {
      request_type req;
      logic        typed;
      outcome_type want;
   } table_row_type;

   logic clock = 0;
   logic reset = 1;
   int   cycle_count = 0;
   int   fail_count = 0;
   bit   stim_done = 0;
   bit   hold_off = 0;

   cpu8ld_req_if req_ch();
   cpu8ld_rsp_if rsp_ch();
   cpu8ld_csr_if csr_ch();

   cpu8_load_execute_unit u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   always #1 clock = ~clock;

   // shadow processor state
   logic [7:0]  regs [8];
   logic [15:0] ix, iy, sp, pc;
   logic [7:0]  ireg, rreg;
   logic [7:0]  mem [MEM_DEPTH];
   bit          written [MEM_DEPTH];
   logic        iff2;
   logic [15:0] scan_pc;
   outcome_type pending_outcomes [$];
   outcome_type typed_outcomes [$];
   bit          typed_flags [$];

   function automatic logic [7:0] mem_read(logic [15:0] a);
      return mem[a & ADDR_MASK];
   endfunction

   function automatic void mem_write(logic [15:0] a, logic [7:0] v, ref outcome_type o);
      mem[a & ADDR_MASK] = v;
      written[a & ADDR_MASK] = 1'b1;
      if (o.write_count == 2'd0) o.write_address = a & ADDR_MASK;
      o.write_count++;
   endfunction

   function automatic logic [7:0] next_byte();
      logic [7:0] b;
      b = mem_read(scan_pc);
      scan_pc++;
      return b;
   endfunction

   function automatic logic [15:0] next_word();
      logic [7:0] lo;
      lo = next_byte();
      return {next_byte(), lo};
   endfunction

   function automatic logic [15:0] pair_read(logic [1:0] p);
      if (p == PAIR_SP) return sp;
      return {regs[{p, 1'b0}], regs[{p, 1'b1}]};
   endfunction

   function automatic void pair_write(logic [1:0] p, logic [15:0] v);
      if (p == PAIR_SP) sp = v;
      else begin
         regs[{p, 1'b0}] = v[15:8];
         regs[{p, 1'b1}] = v[7:0];
      end
   endfunction

   function automatic logic [15:0] word_read(logic [15:0] a);
      return {mem_read(a + 16'd1), mem_read(a)};
   endfunction

   function automatic void word_write(logic [15:0] a, logic [15:0] v, ref outcome_type o);
      mem_write(a, v[7:0], o);
      mem_write(a + 16'd1, v[15:8], o);
   endfunction

   function automatic logic [15:0] disp_addr(logic [15:0] base);
      logic [7:0] d;
      d = next_byte();
      return base + {{8{d[7]}}, d};
   endfunction

   function automatic bit run_plain(logic [7:0] op, ref outcome_type o);
      logic [2:0]  d, s;
      logic [15:0] hl, nn;
      d = op[5:3];
      s = op[2:0];
      hl = pair_read(PAIR_HL);
      if (op >= 8'h40 && op <= 8'h7F && op != OP_HALT) begin
         if (s == REG_MEM) begin
            o.loaded_value = {8'd0, mem_read(hl)}; regs[d] = o.loaded_value[7:0];
            o.t_states = 5'd7;
         end else if (d == REG_MEM) begin
            o.loaded_value = {8'd0, regs[s]}; mem_write(hl, regs[s], o); o.t_states = 5'd7;
         end else begin
            o.loaded_value = {8'd0, regs[s]}; regs[d] = regs[s]; o.t_states = 5'd4;
         end
         return 1'b1;
      end
      if ((op & MASK_RN) == PAT_RN) begin
         o.loaded_value = {8'd0, next_byte()};
         if (d == REG_MEM) begin
            mem_write(hl, o.loaded_value[7:0], o); o.t_states = 5'd10;
         end else begin
            regs[d] = o.loaded_value[7:0]; o.t_states = 5'd7;
         end
         return 1'b1;
      end
      if ((op & MASK_DD) == PAT_DDNN) begin
         o.loaded_value = next_word(); pair_write(op[5:4], o.loaded_value);
         o.t_states = 5'd10;
         return 1'b1;
      end
      case (op)
         OP_A_BC, OP_A_DE: begin
            o.loaded_value = {8'd0, mem_read(pair_read({1'b0, op[4]}))};
            regs[REG_A] = o.loaded_value[7:0]; o.t_states = 5'd7;
         end
         OP_BC_A, OP_DE_A: begin
            o.loaded_value = {8'd0, regs[REG_A]};
            mem_write(pair_read({1'b0, op[4]}), regs[REG_A], o); o.t_states = 5'd7;
         end
         OP_A_NN: begin
            nn = next_word(); o.loaded_value = {8'd0, mem_read(nn)};
            regs[REG_A] = o.loaded_value[7:0]; o.t_states = 5'd13;
         end
         OP_NN_A: begin
            nn = next_word(); o.loaded_value = {8'd0, regs[REG_A]};
            mem_write(nn, regs[REG_A], o); o.t_states = 5'd13;
         end
         OP_HL_NN: begin
            nn = next_word(); o.loaded_value = word_read(nn);
            pair_write(PAIR_HL, o.loaded_value); o.t_states = 5'd16;
         end
         OP_NN_HL: begin
            nn = next_word(); o.loaded_value = hl; word_write(nn, hl, o);
            o.t_states = 5'd16;
         end
         OP_SP_HL: begin
            o.loaded_value = hl; sp = hl; o.t_states = 5'd6;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic bit run_index(logic [7:0] op, ref logic [15:0] xr, ref outcome_type o);
      logic [2:0]  d, s;
      logic [15:0] a;
      d = op[5:3];
      s = op[2:0];
      if (op >= 8'h40 && op <= 8'h7F && op != OP_HALT) begin
         if (s == REG_MEM) begin
            a = disp_addr(xr); o.loaded_value = {8'd0, mem_read(a)};
            regs[d] = o.loaded_value[7:0]; o.t_states = 5'd19; return 1'b1;
         end
         if (d == REG_MEM) begin
            a = disp_addr(xr); o.loaded_value = {8'd0, regs[s]};
            mem_write(a, regs[s], o); o.t_states = 5'd19; return 1'b1;
         end
         return 1'b0;
      end
      case (op)
         OP_XD_N: begin
            a = disp_addr(xr); o.loaded_value = {8'd0, next_byte()};
            mem_write(a, o.loaded_value[7:0], o); o.t_states = 5'd19;
         end
         OP_X_IMM: begin
            o.loaded_value = next_word(); xr = o.loaded_value; o.t_states = 5'd14;
         end
         OP_HL_NN: begin
            a = next_word(); o.loaded_value = word_read(a); xr = o.loaded_value;
            o.t_states = 5'd20;
         end
         OP_NN_HL: begin
            a = next_word(); o.loaded_value = xr; word_write(a, xr, o); o.t_states = 5'd20;
         end
         OP_SP_HL: begin
            o.loaded_value = xr; sp = xr; o.t_states = 5'd10;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic bit run_ed(logic [7:0] op, ref outcome_type o);
      logic [15:0] nn;
      logic [7:0]  v, f;
      if (op == OP_A_I || op == OP_A_R) begin
         v = (op == OP_A_I) ? ireg : rreg;
         regs[REG_A] = v;
         f = (regs[REG_F] & FLAG_KEEP) | (v & FLAG_S);
         if (v == 8'd0) f |= FLAG_Z;
         if (iff2) f |= FLAG_PV;
         regs[REG_F] = f;
         o.loaded_value = {8'd0, v}; o.t_states = 5'd9;
         return 1'b1;
      end
      if (op == OP_I_A) begin
         ireg = regs[REG_A]; o.loaded_value = {8'd0, ireg}; o.t_states = 5'd9; return 1'b1;
      end
      if (op == OP_R_A) begin
         rreg = regs[REG_A]; o.loaded_value = {8'd0, rreg}; o.t_states = 5'd9; return 1'b1;
      end
      if ((op & MASK_DD) == PAT_ED_RD) begin
         nn = next_word(); o.loaded_value = word_read(nn);
         pair_write(op[5:4], o.loaded_value); o.t_states = 5'd20; return 1'b1;
      end
      if ((op & MASK_DD) == PAT_ED_WR) begin
         nn = next_word(); o.loaded_value = pair_read(op[5:4]);
         word_write(nn, o.loaded_value, o); o.t_states = 5'd20; return 1'b1;
      end
      return 1'b0;
   endfunction

   // predicts one response and updates the shadow state
   function automatic outcome_type predict_load(request_type r);
      outcome_type o;
      bit ok;
      o = '0;
      ok = 1'b1;
      scan_pc = pc;
      if (r.kind == KIND_EXEC) begin
         case (r.prefix)
            PFX_NONE: ok = run_plain(r.opcode, o);
            PFX_DD:   ok = run_index(r.opcode, ix, o);
            PFX_FD:   ok = run_index(r.opcode, iy, o);
            default:  ok = run_ed(r.opcode, o);
         endcase
         if (ok) pc = scan_pc;
         else o = '0;
      end else if (r.kind == KIND_PRELOAD) begin
         mem[r.address & ADDR_MASK] = r.data;
         written[r.address & ADDR_MASK] = 1'b1;
      end else if (r.kind == KIND_SETPC) begin
         pc = r.address;
      end
      o.pc_after = pc;
      o.acc_value = regs[REG_A];
      o.flag_value = regs[REG_F];
      o.unsupported = !ok;
      return o;
   endfunction

   // request driver; valid stays up between back to back requests
   task automatic send_request(request_type r, bit typed, outcome_type want);
      int gap;
      outcome_type got;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      got = predict_load(r);
      pending_outcomes.push_back(got);
      typed_flags.push_back(typed);
      typed_outcomes.push_back(want);
      req_ch.valid <= 1'b1;
      req_ch.kind <= r.kind;
      req_ch.prefix <= r.prefix;
      req_ch.opcode <= r.opcode;
      req_ch.address <= r.address;
      req_ch.data <= r.data;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_iff2(logic v);
      csr_ch.valid <= 1'b1;
      csr_ch.iff2_state <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      iff2 = v;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic request_type make_req(logic [1:0] k, logic [1:0] p, logic [7:0] op,
                                            logic [15:0] a, logic [7:0] d);
      request_type r;
      r.kind = k; r.prefix = p; r.opcode = op; r.address = a; r.data = d;
      return r;
   endfunction

   // does any memory read of this instruction hit a never written byte
   function automatic bit reads_unwritten(request_type r);
      logic [7:0]  s_mem [2];
      logic [15:0] hl, bc, de, nn, a;
      logic [7:0]  d8;
      bit bad;
      bad = 1'b0;
      // operand bytes up to three at pc
      for (int k = 0; k < 3; k++) if (!written[16'(pc + 16'(k))]) bad = 1'b1;
      if (bad) return 1'b1;
      // data addresses from the operand bytes
      for (int k = 0; k < 2; k++) s_mem[k] = mem[16'(pc + 16'(k))];
      hl = {regs[4], regs[5]}; bc = {regs[0], regs[1]}; de = {regs[2], regs[3]};
      nn = {s_mem[1], s_mem[0]};
      d8 = s_mem[0];
      if (r.prefix == PFX_NONE) begin
         if (r.opcode >= 8'h40 && r.opcode <= 8'h7F && r.opcode[2:0] == REG_MEM)
            bad = !written[hl];
         else if (r.opcode == OP_A_BC) bad = !written[bc];
         else if (r.opcode == OP_A_DE) bad = !written[de];
         else if (r.opcode == OP_A_NN) bad = !written[nn];
         else if (r.opcode == OP_HL_NN) bad = !written[nn] || !written[nn + 16'd1];
      end else if (r.prefix != PFX_ED) begin
         a = ((r.prefix == PFX_DD) ? ix : iy) + {{8{d8[7]}}, d8};
         if (r.opcode >= 8'h40 && r.opcode <= 8'h7F && r.opcode[2:0] == REG_MEM)
            bad = !written[a];
         else if (r.opcode == OP_HL_NN) bad = !written[nn] || !written[nn + 16'd1];
      end else if ((r.opcode & MASK_DD) == PAT_ED_RD)
         bad = !written[nn] || !written[nn + 16'd1];
      return bad;
   endfunction

   // random instruction, mostly loads; 1 in 8 is arbitrary
   function automatic request_type rand_exec();
      logic [7:0] plain_ops [] = '{8'h40, 8'h06, 8'h01, OP_A_BC, OP_A_DE, OP_BC_A, OP_DE_A,
                                   OP_A_NN, OP_NN_A, OP_HL_NN, OP_NN_HL, OP_SP_HL};
      logic [7:0] idx_ops [] = '{8'h46, 8'h70, OP_XD_N, OP_X_IMM, OP_HL_NN, OP_NN_HL, OP_SP_HL};
      logic [7:0] ed_ops [] = '{OP_A_I, OP_A_R, OP_I_A, OP_R_A, PAT_ED_RD, PAT_ED_WR};
      logic [1:0] p;
      logic [7:0] op;
      p = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) op = 8'($urandom);
      else case (p)
         PFX_NONE: begin
            op = plain_ops[$urandom_range(0, plain_ops.size() - 1)];
            if (op == 8'h40) op = 8'h40 | (8'($urandom) & 8'h3F);
            else if (op == 8'h06) op = 8'h06 | (8'($urandom) & 8'h38);
            else if (op == 8'h01) op = 8'h01 | (8'($urandom) & 8'h30);
         end
         PFX_ED: begin
            op = ed_ops[$urandom_range(0, ed_ops.size() - 1)];
            if (op == PAT_ED_RD || op == PAT_ED_WR) op = op | (8'($urandom) & 8'h30);
         end
         default: begin
            op = idx_ops[$urandom_range(0, idx_ops.size() - 1)];
            if (op == 8'h46) op = 8'h46 | (8'($urandom) & 8'h38);
            else if (op == 8'h70) op = 8'h70 | (8'($urandom) & 8'h07);
         end
      endcase
      return make_req(KIND_EXEC, p, op, 16'($urandom), 8'($urandom));
   endfunction

   // stimulus
   initial begin
      table_row_type rows [$];
      table_row_type row;
      request_type r;
      outcome_type none;
      none = '0;
      foreach (regs[k]) regs[k] = '0;
      ix = '0; iy = '0; sp = '0; pc = '0; ireg = '0; rreg = '0; iff2 = 1'b0;
      req_ch.valid <= 1'b0; req_ch.kind <= '0; req_ch.prefix <= '0; req_ch.opcode <= '0;
      req_ch.address <= '0; req_ch.data <= '0;
      csr_ch.valid <= 1'b0; csr_ch.iff2_state <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; typed rows carry a literal result
      row.typed = 1;
      row.req = make_req(KIND_EXEC, PFX_NONE, OP_HALT, 16'h0000, 8'h00);
      row.want = '{pc_after: 0, unsupported: 1, default: 0};
      rows.push_back(row);
      row.req = make_req(KIND_EXEC, PFX_ED, OP_A_I, 16'h0000, 8'h00);
      row.want = '{flag_value: FLAG_Z, loaded_value: 0, t_states: 9, default: 0};
      rows.push_back(row);
      row.req = make_req(KIND_SETPC, PFX_NONE, 8'h00, 16'hFFFF, 8'h00);
      row.want = '{pc_after: 16'hFFFF, flag_value: FLAG_Z, default: 0};
      rows.push_back(row);
      row.req = make_req(KIND_PRELOAD, PFX_NONE, 8'h00, 16'hFFFF, 8'hFF);
      row.want = '{pc_after: 16'hFFFF, flag_value: FLAG_Z, default: 0};
      rows.push_back(row);
      row.typed = 0;
      begin
         // operand bytes spanning the pc wrap and a few data bytes
         request_type pre [] = '{
            make_req(KIND_PRELOAD, PFX_NONE, 8'h00, 16'h0000, 8'h80),
            make_req(KIND_PRELOAD, PFX_NONE, 8'h00, 16'h0001, 8'h7F),
            make_req(KIND_PRELOAD, PFX_NONE, 8'h00, 16'h0002, 8'h00),
            make_req(KIND_PRELOAD, PFX_NONE, 8'h00, 16'h0003, 8'h00),
            make_req(KIND_EXEC, PFX_NONE, 8'h3E, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_NONE, 8'h21, 16'h0000, 8'h00),
            make_req(KIND_SETPC, PFX_NONE, 8'h00, 16'h0001, 8'h00),
            make_req(KIND_EXEC, PFX_DD, OP_X_IMM, 16'h0000, 8'h00),
            make_req(KIND_SETPC, PFX_NONE, 8'h00, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_DD, OP_XD_N, 16'h0000, 8'h00),
            make_req(KIND_SETPC, PFX_NONE, 8'h00, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_NONE, OP_NN_A, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_ED, OP_I_A, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_ED, OP_A_R, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_ED, OP_R_A, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_ED, OP_A_R, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_FD, OP_SP_HL, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_DD, 8'h44, 16'h0000, 8'h00),
            make_req(KIND_EXEC, PFX_ED, 8'hFF, 16'h0000, 8'h00)};
         foreach (pre[k]) begin
            row.req = pre[k];
            rows.push_back(row);
         end
      end
      foreach (rows[k]) begin
         send_request(rows[k].req, rows[k].typed, rows[k].typed ? rows[k].want : none);
         if (k == 2) begin
            wait_drained();
            write_iff2(1'b1);
         end
      end

      // random phases across both iff2 settings
      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         write_iff2(phase[0]);
         if (phase == 2) hold_off = 1;
         for (int n = 0; n < RANDOM_COUNT / 4; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: r = make_req(KIND_PRELOAD, 2'($urandom), 8'($urandom),
                                      (phase < 2) ? 16'($urandom_range(0, 63))
                                                  : 16'($urandom), 8'($urandom));
               3: r = make_req(KIND_SETPC, 2'($urandom), 8'($urandom),
                               16'($urandom_range(0, 63)), 8'($urandom));
               4: r = make_req(KIND_NOP, 2'($urandom), 8'($urandom), 16'($urandom),
                               8'($urandom));
               default: r = rand_exec();
            endcase
            if (r.kind == KIND_EXEC && reads_unwritten(r)) begin
               n--;
               r = make_req(KIND_PRELOAD, PFX_NONE, 8'h00, 16'($urandom), 8'($urandom));
               for (int k = 0; k < MEM_DEPTH && written[r.address]; k++) r.address++;
            end
            send_request(r, 0, none);
            if (n == 10) hold_off = 0;
         end
      end
      wait_drained();
      stim_done = 1;
   end

   // response checker and receiver stalls
   initial begin
      int gap;
      int stall;
      outcome_type want, got, typed_want;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = hold_off ? 200 : 0;
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap + stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap + stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.pc_after = rsp_ch.pc_after;
         got.acc_value = rsp_ch.acc_value;
         got.flag_value = rsp_ch.flag_value;
         got.loaded_value = rsp_ch.loaded_value;
         got.write_count = rsp_ch.write_count;
         got.write_address = rsp_ch.write_address;
         got.t_states = rsp_ch.t_states;
         got.unsupported = rsp_ch.unsupported;
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            typed_want = typed_outcomes.pop_front();
            if (typed_flags.pop_front()) want = typed_want;
            if (got.pc_after !== want.pc_after) begin
               $error("pc_after exp %h got %h", want.pc_after, got.pc_after); fail_count++;
            end
            if (got.acc_value !== want.acc_value) begin
               $error("acc_value exp %h got %h", want.acc_value, got.acc_value); fail_count++;
            end
            if (got.flag_value !== want.flag_value) begin
               $error("flag_value exp %h got %h", want.flag_value, got.flag_value);
               fail_count++;
            end
            if (got.loaded_value !== want.loaded_value) begin
               $error("loaded_value exp %h got %h", want.loaded_value, got.loaded_value);
               fail_count++;
            end
            if (got.write_count !== want.write_count) begin
               $error("write_count exp %h got %h", want.write_count, got.write_count);
               fail_count++;
            end
            if (got.write_address !== want.write_address) begin
               $error("write_address exp %h got %h", want.write_address, got.write_address);
               fail_count++;
            end
            if (got.t_states !== want.t_states) begin
               $error("t_states exp %0d got %0d", want.t_states, got.t_states); fail_count++;
            end
            if (got.unsupported !== want.unsupported) begin
               $error("unsupported exp %b got %b", want.unsupported, got.unsupported);
               fail_count++;
            end
         end
      end
   end

   // end of run and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stim_done) begin
         if (fail_count == 0 && pending_outcomes.size() == 0)
            $display("cpu8_load_execute_unit_test OK");
         else
            $display("cpu8_load_execute_unit_test NOT OK");
         $finish;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("cpu8_load_execute_unit_test NOT OK");
         $finish;
      end
   end

endmodule
